@@ hw/rtl/lcgd_pkg.sv @@
// ----------------------------------------------------------------------------
// LED colour gamma dimmer package
// Shared types, constants and elaboration-time tables of the gamma dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgd_pkg;

  localparam int NUM_CH        = 5;
  localparam int CH_W          = 8;
  localparam int LVL_W         = 16;
  localparam int PCT_W         = 7;
  localparam int LQ_W          = 25;
  localparam int RES_W         = 5;
  localparam int DEF_MAX_DUTY_BITS = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 80;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [RES_W-1:0] RES_RESET = 5'd8;
  localparam int COOL_CH       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_MODE     = 2'd0,
    REG_DUTY_RESOLUTION = 2'd1
  } reg_idx_t;

  typedef logic [LVL_W-1:0] gamma_rom_t [256];
  typedef logic [CH_W-1:0]  pixel_rom_t [256];
  typedef logic [LQ_W-1:0]  light_rom_t [101];

  typedef struct packed {
    logic [NUM_CH-1:0][LVL_W-1:0] gam;
    logic [NUM_CH-1:0][CH_W-1:0]  pix;
    logic [PCT_W-1:0]             pct;
    logic [LQ_W-1:0]              lq;
    logic [LVL_W-1:0]             fs;
    logic                         duty;
    logic                         zero;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic [1:0] count;
  } queue_stat_t;

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t rom;
    logic [191:0] rhs;
    logic [191:0] lhs;
    int lo;
    int hi;
    int mid;
    for (int i = 0; i < 256; i++) begin
      rhs = 192'd32;
      for (int k = 0; k < 5; k++) rhs = rhs * 192'd257;
      for (int k = 0; k < 11; k++) rhs = rhs * 192'(i);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 192'd1;
        for (int k = 0; k < 5; k++) lhs = lhs * 192'(2 * mid - 1);
        for (int k = 0; k < 6; k++) lhs = lhs * 192'd255;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      rom[i] = LVL_W'(lo);
    end
    return rom;
  endfunction

  function automatic pixel_rom_t build_pixel(gamma_rom_t g);
    pixel_rom_t rom;
    logic [31:0] v;
    for (int i = 0; i < 256; i++) begin
      v = (32'(g[i]) * 32'd255 + 32'd32767) / 32'd65535;
      rom[i] = CH_W'(v);
    end
    return rom;
  endfunction

  function automatic light_rom_t build_light();
    light_rom_t rom;
    logic [63:0] num;
    logic [63:0] v;
    localparam logic [63:0] Den = 64'd5920 * 64'd5920 * 64'd5920;
    for (int b = 0; b <= 100; b++) begin
      if (b <= 8) begin
        v = (64'd51 * 64'(b) * 64'd16777216 + 64'd23000) / 64'd46000;
      end else begin
        num = 64'd51 * 64'(b) + 64'd820;
        v = (num * num * num * 64'd16777216 + Den / 64'd2) / Den;
      end
      rom[b] = LQ_W'(v);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();
  localparam pixel_rom_t PIXEL_ROM = build_pixel(GAMMA_ROM);
  localparam light_rom_t LIGHT_ROM = build_light();

endpackage

`default_nettype wire

@@ hw/rtl/lcgd_front.sv @@
// ----------------------------------------------------------------------------
// LED colour gamma dimmer front end
// Accepts a colour word, looks up gamma and lightness and classifies the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgd_front import lcgd_pkg::*; #(
  parameter int MAX_DUTY_BITS = DEF_MAX_DUTY_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  mode_duty,
  input  wire logic [RES_W-1:0]      duty_res,
  input  wire logic                  q_full,
  output logic                       push,
  output item_t                      push_item
);

  localparam logic [RES_W-1:0] MaxBits = RES_W'(MAX_DUTY_BITS);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic [CH_W-1:0]  ch;
  logic [CH_W-1:0]  pct_raw;
  logic [PCT_W-1:0] pct;
  logic [RES_W-1:0] bits;

  always_comb begin
    item_nxt = item_r;
    pct_raw  = in_tdata[NUM_CH*CH_W +: CH_W];
    pct      = (pct_raw > CH_W'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];
    bits     = (duty_res > MaxBits) ? MaxBits : duty_res;
    ch       = '0;
    for (int j = 0; j < NUM_CH; j++) begin
      ch = in_tdata[j*CH_W +: CH_W];
      item_nxt.gam[j] = GAMMA_ROM[ch];
      item_nxt.pix[j] = PIXEL_ROM[ch];
    end
    item_nxt.pct  = pct;
    item_nxt.lq   = LIGHT_ROM[pct];
    item_nxt.fs   = LVL_W'((17'd1 << bits) - 17'd1);
    item_nxt.duty = mode_duty;
    item_nxt.zero = (pct_raw == '0) || (mode_duty && duty_res == '0);
  end

  assign push      = valid_r && !q_full;
  assign push_item = item_r;
  assign in_tready = !valid_r || !q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lcgd_queue.sv @@
// ----------------------------------------------------------------------------
// LED colour gamma dimmer queue
// Two-entry queue between the front end and the scaling back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgd_queue import lcgd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output queue_stat_t stat
);

  item_t mem [QUEUE_DEPTH];
  logic  wr_r;
  logic  wr_nxt;
  logic  rd_r;
  logic  rd_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic  do_pop;

  assign stat.count = count_r;
  assign stat.empty = (count_r == 2'd0);
  assign stat.full  = (count_r == 2'd2);
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_r];

  always_comb begin
    wr_nxt    = push ? !wr_r : wr_r;
    rd_nxt    = do_pop ? !rd_r : rd_r;
    count_nxt = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lcgd_back.sv @@
// ----------------------------------------------------------------------------
// LED colour gamma dimmer back end
// Three-stage scaling pipeline for pixel and duty output, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgd_back import lcgd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire item_t                  q_item,
  output logic                        pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam logic [56:0] HalfQ = 57'd65535 << 23;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [NUM_CH-1:0][40:0] m1_r;
  logic [NUM_CH-1:0][14:0] px1_r;
  logic [NUM_CH-1:0]       plit1_r, dlit1_r;
  logic [LVL_W-1:0]        fs1_r;
  logic                    duty1_r, zero1_r;

  logic [NUM_CH-1:0][56:0] m2_r;
  logic [NUM_CH-1:0][7:0]  px2_r;
  logic [NUM_CH-1:0]       plit2_r, dlit2_r;
  logic                    duty2_r, zero2_r;

  logic [NUM_CH-1:0][LVL_W-1:0] res_r;
  logic [NUM_CH-1:0][LVL_W-1:0] res_nxt;

  logic [CH_W-1:0]  pmax;
  logic [LVL_W-1:0] gmax;
  logic [NUM_CH-1:0] plit_nxt, dlit_nxt;
  logic [NUM_CH-1:0][27:0] pprod;
  logic [33:0] t;
  logic [34:0] s;

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign pop  = rdy1 && q_valid;

  always_comb begin
    pmax = q_item.pix[0];
    gmax = q_item.gam[0];
    for (int j = 1; j < 3; j++) begin
      if (q_item.pix[j] > pmax) pmax = q_item.pix[j];
      if (q_item.gam[j] > gmax) gmax = q_item.gam[j];
    end
    for (int j = 0; j < NUM_CH; j++) begin
      if (j < 3) begin
        plit_nxt[j] = q_item.pix[j] > ((pmax >> 2) + 8'd1);
        dlit_nxt[j] = 17'(q_item.gam[j]) > (17'(gmax >> 2) + 17'd1);
      end else begin
        plit_nxt[j] = q_item.pix[j] != '0;
        dlit_nxt[j] = q_item.gam[j] != '0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_CH; j++) begin
      pprod[j] = (28'(px1_r[j]) + 28'd50) * 28'd5243;
    end
  end

  always_comb begin
    res_nxt = '0;
    t       = '0;
    s       = '0;
    for (int j = 0; j < NUM_CH; j++) begin
      t = 34'((m2_r[j] + HalfQ) >> 24);
      s = (35'(t) + 35'(t >> 16) + 35'd1) >> 16;
      if (duty2_r) begin
        res_nxt[j] = (s[15:0] == '0 && dlit2_r[j]) ? 16'd1 : s[15:0];
      end else if (j != COOL_CH) begin
        res_nxt[j] = {8'd0, (px2_r[j] == '0 && plit2_r[j]) ? 8'd1 : px2_r[j]};
      end
      if (zero2_r) res_nxt[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= q_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
    if (rdy1) begin
      for (int j = 0; j < NUM_CH; j++) begin
        m1_r[j]  <= 41'(q_item.gam[j]) * 41'(q_item.lq);
        px1_r[j] <= 15'(q_item.pix[j]) * 15'(q_item.pct);
      end
      plit1_r <= plit_nxt;
      dlit1_r <= dlit_nxt;
      fs1_r   <= q_item.fs;
      duty1_r <= q_item.duty;
      zero1_r <= q_item.zero;
    end
    if (rdy2) begin
      for (int j = 0; j < NUM_CH; j++) begin
        m2_r[j]  <= 57'(m1_r[j]) * 57'(fs1_r);
        px2_r[j] <= pprod[j][26:19];
      end
      plit2_r <= plit1_r;
      dlit2_r <= dlit1_r;
      duty2_r <= duty1_r;
      zero2_r <= zero1_r;
    end
    if (rdy3) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/led_color_gamma_dimmer_unit.sv @@
// ----------------------------------------------------------------------------
// LED colour gamma dimmer
// Gamma correction and brightness scaling of RGBCW colours for pixels or PWM.
// ----------------------------------------------------------------------------
// Accepted words pass the front register, queue, scaling stages and output register.
// Throughput: one word per cycle while out_tready stays high, set by the fully pipelined multipliers.
// The front register, two-entry queue and output register stall independently.
// Reset clears all handshake state; output_mode resets to 0, duty_resolution to 8.
`default_nettype none

module led_color_gamma_dimmer_unit import lcgd_pkg::*; #(
  parameter int MAX_DUTY_BITS = DEF_MAX_DUTY_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // red_in, green_in, blue_in, cool_in, white_in, brightness_pct
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // red_out, green_out, blue_out, cool_out, white_out
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic             mode_r;
  logic [RES_W-1:0] res_r;
  logic             push;
  logic             pop;
  item_t            push_item;
  item_t            head;
  queue_stat_t      qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      res_r  <= RES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OUTPUT_MODE:     mode_r <= cfg_data[0];
        REG_DUTY_RESOLUTION: res_r  <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  lcgd_front #(.MAX_DUTY_BITS(MAX_DUTY_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .mode_duty (mode_r),
    .duty_res  (res_r),
    .q_full    (qstat.full),
    .push      (push),
    .push_item (push_item)
  );

  lcgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  lcgd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!qstat.empty),
    .q_item     (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !(push && !pop)) else $error("push into full queue");
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule

`default_nettype wire

@@ tb/led_color_gamma_dimmer_unit_test.sv @@
// ----------------------------------------------------------------------------
// LED colour gamma dimmer testbench
// Drives colour words with random gaps and register writes through the config port,
// stalls the output stream at random, predicts every output word and checks it
// field by field in a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module led_color_gamma_dimmer_unit_test;
  import lcgd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [15:0] white;
    logic [15:0] cool;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } levels_t;

  class dimmer_scoreboard;
    logic [15:0] curve_lut[256];
    logic [63:0] light_lut[101];
    bit          duty_mode;
    logic [4:0]  timer_bits;
    levels_t     pending_levels[$];
    int          failures;

    function new();
      logic [159:0] limit;
      logic [159:0] trial;
      logic [15:0]  n;
      logic [15:0]  t;
      logic [63:0]  c;
      for (int i = 0; i < 256; i++) begin
        limit = 160'd32;
        repeat (5) limit = limit * 160'd257;
        repeat (11) limit = limit * 160'(i);
        n = '0;
        for (int bitpos = 15; bitpos >= 0; bitpos--) begin
          t = n | (16'd1 << bitpos);
          trial = 160'd1;
          repeat (5) trial = trial * (160'(t) * 160'd2 - 160'd1);
          repeat (6) trial = trial * 160'd255;
          if (trial <= limit) n = t;
        end
        curve_lut[i] = n;
      end
      for (int b = 0; b <= 100; b++) begin
        if (b <= 8) begin
          light_lut[b] = (64'd51 * 64'(b) * 64'd16777216 + 64'd23000) / 64'd46000;
        end else begin
          c = 64'd51 * 64'(b) + 64'd820;
          light_lut[b] = (c * c * c * 64'd16777216 + 64'd103737344000 / 2)
                         / 64'd207474688000;
        end
      end
      duty_mode = 0;
      timer_bits = 5'd8;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_OUTPUT_MODE) duty_mode = val[0];
      else if (idx == REG_DUTY_RESOLUTION) timer_bits = val[4:0];
    endfunction

    function logic [15:0] keep_lit(logic [15:0] scaled, logic [15:0] level,
                                   logic [15:0] floor_lvl);
      return (scaled == 0 && level > floor_lvl) ? 16'd1 : scaled;
    endfunction

    function logic [15:0] duty_of(logic [15:0] level, logic [6:0] pct, logic [63:0] fs);
      logic [63:0] q;
      q = 64'd65535 << 24;
      return 16'((64'(level) * light_lut[pct] * fs + q / 64'd2) / q);
    endfunction

    function logic [15:0] pixel_of(logic [15:0] level, logic [6:0] pct);
      return 16'((32'(level) * 32'(pct) + 32'd50) / 32'd100);
    endfunction

    function void note_word(logic [IN_TDATA_W-1:0] word);
      levels_t     lv;
      logic [15:0] lvl[5];
      logic [15:0] top;
      logic [15:0] floor_lvl;
      logic [63:0] fs;
      logic [6:0]  pct;
      int          bits;
      lv = '0;
      pct = word[47:40] > 8'd100 ? 7'd100 : word[46:40];
      if (word[47:40] != 0 && (!duty_mode || timer_bits != 0)) begin
        for (int j = 0; j < 5; j++) begin
          lvl[j] = curve_lut[word[j*8 +: 8]];
          if (!duty_mode) lvl[j] = 16'((32'(lvl[j]) * 32'd255 + 32'd32767) / 32'd65535);
        end
        top = lvl[0] > lvl[1] ? lvl[0] : lvl[1];
        if (lvl[2] > top) top = lvl[2];
        floor_lvl = (top >> 2) + 16'd1;
        if (!duty_mode) begin
          lv.red   = keep_lit(pixel_of(lvl[0], pct), lvl[0], floor_lvl);
          lv.green = keep_lit(pixel_of(lvl[1], pct), lvl[1], floor_lvl);
          lv.blue  = keep_lit(pixel_of(lvl[2], pct), lvl[2], floor_lvl);
          lv.white = keep_lit(pixel_of(lvl[4], pct), lvl[4], 16'd0);
        end else begin
          bits = timer_bits > 5'd16 ? 16 : int'(timer_bits);
          fs = (64'd1 << bits) - 64'd1;
          lv.red   = keep_lit(duty_of(lvl[0], pct, fs), lvl[0], floor_lvl);
          lv.green = keep_lit(duty_of(lvl[1], pct, fs), lvl[1], floor_lvl);
          lv.blue  = keep_lit(duty_of(lvl[2], pct, fs), lvl[2], floor_lvl);
          lv.cool  = keep_lit(duty_of(lvl[3], pct, fs), lvl[3], 16'd0);
          lv.white = keep_lit(duty_of(lvl[4], pct, fs), lvl[4], 16'd0);
        end
      end
      pending_levels.push_back(lv);
    endfunction

    function void check_word(levels_t got);
      levels_t want;
      if (pending_levels.size() == 0) begin
        $error("output word with no expectation: %h", got);
        failures++;
        return;
      end
      want = pending_levels.pop_front();
      if (got.red != want.red) begin
        $error("red_out expected %0d got %0d", want.red, got.red);
        failures++;
      end
      if (got.green != want.green) begin
        $error("green_out expected %0d got %0d", want.green, got.green);
        failures++;
      end
      if (got.blue != want.blue) begin
        $error("blue_out expected %0d got %0d", want.blue, got.blue);
        failures++;
      end
      if (got.cool != want.cool) begin
        $error("cool_out expected %0d got %0d", want.cool, got.cool);
        failures++;
      end
      if (got.white != want.white) begin
        $error("white_out expected %0d got %0d", want.white, got.white);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tvalid;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dimmer_scoreboard board;
  bit steady;
  int rx_long_hold;
  int cycles = 0;

  led_color_gamma_dimmer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_word(in_tdata);
      if (out_tvalid && out_tready) board.check_word(out_tdata);
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("led_color_gamma_dimmer_unit_test failed");
      $finish;
    end
  end

  initial begin
    int n;
    bit held;
    held = 0;
    out_tready <= 0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      n = steady ? 0 : $urandom_range(0, 12);
      if (rx_long_hold > 0 && !held) begin
        n = rx_long_hold;
        held = 1;
      end
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] c, logic [7:0] w, logic [7:0] pct);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {pct, w, c, b, g, r};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending_levels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 12));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_pct();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'($urandom_range(101, 255));
      2: return 8'($urandom_range(1, 9));
      default: return 8'($urandom_range(1, 100));
    endcase
  endfunction

  task automatic directed_set();
    send_word(0, 0, 0, 0, 0, 100);
    send_word(255, 255, 255, 255, 255, 100);
    send_word(255, 255, 255, 255, 255, 0);
    send_word(255, 255, 255, 255, 255, 255);
    send_word(200, 100, 50, 25, 10, 101);
    send_word(255, 40, 1, 1, 1, 1);
    send_word(255, 30, 20, 8, 8, 8);
    send_word(90, 255, 60, 5, 5, 9);
    send_word(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 50);
    send_word(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h80);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) steady = 1;
      if (i == count / 2 + 20) steady = 0;
      send_word(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                pick_channel(), pick_pct());
    end
  endtask

  initial begin
    board = new();
    steady = 0;
    rx_long_hold = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    cfg_valid <= 0;
    cfg_index <= REG_OUTPUT_MODE;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    directed_set();
    random_phase(150);
    write_reg(REG_OUTPUT_MODE, 8'd1);
    directed_set();
    rx_long_hold = 300;
    steady = 1;
    random_phase(30);
    steady = 0;
    random_phase(120);
    write_reg(REG_DUTY_RESOLUTION, 8'd16);
    directed_set();
    random_phase(150);
    write_reg(REG_DUTY_RESOLUTION, 8'd1);
    random_phase(120);
    write_reg(REG_DUTY_RESOLUTION, 8'd0);
    directed_set();
    random_phase(60);
    write_reg(REG_DUTY_RESOLUTION, 8'd31);
    random_phase(120);
    write_reg(REG_DUTY_RESOLUTION, 8'hEC);
    random_phase(120);
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    random_phase(60);
    write_reg(REG_DUTY_RESOLUTION, 8'd11);
    random_phase(150);
    write_reg(REG_OUTPUT_MODE, 8'hFE);
    random_phase(150);
    write_reg(REG_DUTY_RESOLUTION, 8'd0);
    random_phase(100);
    write_reg(REG_OUTPUT_MODE, 8'd1);
    write_reg(REG_DUTY_RESOLUTION, 8'd5);
    random_phase(150);

    drain();
    if (board.failures == 0) begin
      $display("led_color_gamma_dimmer_unit_test passed");
    end else begin
      $display("led_color_gamma_dimmer_unit_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
